@@ rtl/core/lav_pkg.sv @@
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and constants for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [31:0] q16_t;

  // Unit length in Q1.14
  localparam int Q14_ONE  = 16384;
  // Half of one Q1.14 step, for round half away from zero
  localparam int RND_HALF = 8192;
  // Normalized magnitudes keep their leading one at this bit
  localparam int NORM_MSB = 23;
  // Normalized magnitude width
  localparam int NM_W     = 24;
  // Sum of three squared normalized magnitudes
  localparam int SUM_W    = 50;
  // Root bits, one per square root stage
  localparam int ROOT_W   = 25;
  // Quotient bits, one per divide stage
  localparam int QUO_W    = 15;
  // Register depth of one normalize unit
  localparam int NORM_LAT = 6 + ROOT_W + QUO_W + 2;

endpackage

`default_nettype wire

@@ rtl/core/lav_delay.sv @@
// ----------------------------------------------------------------------------
// lav_delay
// Enable-gated shift line that keeps side data aligned with a long unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  logic [W-1:0] tap_r [DEPTH];

  // Advance the line on every enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

`default_nettype wire

@@ rtl/core/lav_norm.sv @@
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: block-float the magnitudes, exact integer
// square root one bit a stage, then one quotient bit a stage per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_norm
  import lav_pkg::*;
#(
  parameter int W = 33
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_v,
  input  wire logic signed [W-1:0] in_vec [3],
  output logic                     out_v,
  output q14_t                     out_vec [3]
);

  localparam int PW  = $clog2(W);
  localparam int REM_W = ROOT_W + 2;
  localparam int DIV_W = NM_W + 14 + 2;

  // stage 1: magnitudes
  logic         v1_r;
  logic [W-1:0] mag1_r [3];
  logic [2:0]   neg1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_r[i] <= in_vec[i][W-1];
        mag1_r[i] <= in_vec[i][W-1] ? W'(-in_vec[i]) : W'(in_vec[i]);
      end
    end
  end

  // stage 2: largest magnitude
  logic         v2_r;
  logic [W-1:0] mag2_r [3];
  logic [2:0]   neg2_r;
  logic [W-1:0] max2_r;
  logic [W-1:0] max_nxt;

  always_comb begin
    max_nxt = (mag1_r[0] > mag1_r[1]) ? mag1_r[0] : mag1_r[1];
    if (mag1_r[2] > max_nxt) begin
      max_nxt = mag1_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
      max2_r <= max_nxt;
    end
  end

  // stage 3: leading one of the largest magnitude
  logic          v3_r;
  logic [W-1:0]  mag3_r [3];
  logic [2:0]    neg3_r;
  logic [PW-1:0] lead3_r;
  logic          zero3_r;
  logic [PW-1:0] lead_nxt;

  always_comb begin
    lead_nxt = '0;
    for (int b = 0; b < W; b++) begin
      if (max2_r[b]) begin
        lead_nxt = PW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag3_r  <= mag2_r;
      neg3_r  <= neg2_r;
      lead3_r <= lead_nxt;
      zero3_r <= (max2_r == '0);
    end
  end

  // stage 4: shift so the leading one lands on NORM_MSB
  logic            v4_r;
  logic [NM_W-1:0] nm4_r [3];
  logic [2:0]      neg4_r;
  logic            zero4_r;
  logic [W-1:0]    sh_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead3_r >= PW'(NORM_MSB)) begin
        sh_nxt[i] = mag3_r[i] >> (lead3_r - PW'(NORM_MSB));
      end else begin
        sh_nxt[i] = mag3_r[i] << (PW'(NORM_MSB) - lead3_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nm4_r[i] <= sh_nxt[i][NM_W-1:0];
      end
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
    end
  end

  // stage 5: squares
  logic              v5_r;
  logic [NM_W-1:0]   nm5_r [3];
  logic [2:0]        neg5_r;
  logic              zero5_r;
  logic [2*NM_W-1:0] sq5_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq5_r[i] <= (2*NM_W)'(nm4_r[i]) * (2*NM_W)'(nm4_r[i]);
      end
      nm5_r   <= nm4_r;
      neg5_r  <= neg4_r;
      zero5_r <= zero4_r;
    end
  end

  // stage 6 and square root chain: element 0 holds the sum of squares
  logic              rv_r   [ROOT_W+1];
  logic [SUM_W-1:0]  rad_r  [ROOT_W+1];
  logic [REM_W-1:0]  rrem_r [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];
  logic [NM_W-1:0]   rnm_r  [ROOT_W+1][3];
  logic [2:0]        rneg_r [ROOT_W+1];
  logic              rzero_r[ROOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r[0] <= 1'b0;
    end else if (en) begin
      rv_r[0] <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]   <= SUM_W'(sq5_r[0]) + SUM_W'(sq5_r[1]) + SUM_W'(sq5_r[2]);
      rrem_r[0]  <= '0;
      root_r[0]  <= '0;
      rnm_r[0]   <= nm5_r;
      rneg_r[0]  <= neg5_r;
      rzero_r[0] <= zero5_r;
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    logic [REM_W+1:0] t_nxt;
    logic [REM_W+1:0] trial_nxt;

    assign t_nxt     = {rrem_r[k], rad_r[k][SUM_W-1 -: 2]};
    assign trial_nxt = (REM_W+2)'({root_r[k], 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[k+1] <= 1'b0;
      end else if (en) begin
        rv_r[k+1] <= rv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1] <= rad_r[k] << 2;
        if (t_nxt >= trial_nxt) begin
          rrem_r[k+1] <= REM_W'(t_nxt - trial_nxt);
          root_r[k+1] <= {root_r[k][ROOT_W-2:0], 1'b1};
        end else begin
          rrem_r[k+1] <= REM_W'(t_nxt);
          root_r[k+1] <= {root_r[k][ROOT_W-2:0], 1'b0};
        end
        rnm_r[k+1]   <= rnm_r[k];
        rneg_r[k+1]  <= rneg_r[k];
        rzero_r[k+1] <= rzero_r[k];
      end
    end
  end

  // divide chain: element 0 holds the rounded numerators
  logic              dv_r   [QUO_W+1];
  logic [DIV_W-1:0]  drem_r [QUO_W+1][3];
  logic [ROOT_W-1:0] dden_r [QUO_W+1];
  logic [QUO_W-1:0]  dq_r   [QUO_W+1][3];
  logic [2:0]        dneg_r [QUO_W+1];
  logic              dzero_r[QUO_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= rv_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= DIV_W'({rnm_r[ROOT_W][i], 14'b0})
                      + DIV_W'(root_r[ROOT_W] >> 1);
        dq_r[0][i]   <= '0;
      end
      dden_r[0]  <= root_r[ROOT_W];
      dneg_r[0]  <= rneg_r[ROOT_W];
      dzero_r[0] <= rzero_r[ROOT_W];
    end
  end

  // one quotient bit per stage, three lanes
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int KB = QUO_W - 1 - j;
    logic [DIV_W-1:0] sub_nxt;

    assign sub_nxt = DIV_W'(dden_r[j]) << KB;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (drem_r[j][i] >= sub_nxt) begin
            drem_r[j+1][i] <= drem_r[j][i] - sub_nxt;
            dq_r[j+1][i]   <= dq_r[j][i] | (QUO_W'(1) << KB);
          end else begin
            drem_r[j+1][i] <= drem_r[j][i];
            dq_r[j+1][i]   <= dq_r[j][i];
          end
        end
        dden_r[j+1]  <= dden_r[j];
        dneg_r[j+1]  <= dneg_r[j];
        dzero_r[j+1] <= dzero_r[j];
      end
    end
  end

  // final stage: restore signs, force zero-length vectors to zero
  logic out_v_r;
  q14_t out_vec_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dzero_r[QUO_W]) begin
          out_vec_r[i] <= '0;
        end else if (dneg_r[QUO_W][i]) begin
          out_vec_r[i] <= -q14_t'(dq_r[QUO_W][i]);
        end else begin
          out_vec_r[i] <= q14_t'(dq_r[QUO_W][i]);
        end
      end
    end
  end

  assign out_v   = out_v_r;
  assign out_vec = out_vec_r;

endmodule

`default_nettype wire

@@ rtl/core/look_at_view_matrix.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix: rotation in Q1.14, translation in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one word per camera: eye, target and up, each a
//   signed Q16.16 3-vector. The result channel returns one word per input:
//   the 3x3 rotation (right, up, forward axes as columns) and the saturated
//   translation. Both channels use valid/stall; a word moves when valid is
//   high and stall is low.
//   The pipeline takes one word per cycle while in_stall is low; the two
//   normalize units (square root and divide, one bit per stage each) set
//   the depth.
//   When the receiver stalls, the result in the output register holds and
//   one more word lands in a skid register; after that the whole pipeline
//   freezes and in_stall rises until the receiver takes a word.
//   Reset (rst_n low, synchronous) clears every valid bit; no word is in
//   flight afterwards and in_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix
  import lav_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire q16_t in_eye_x,
  input  wire q16_t in_eye_y,
  input  wire q16_t in_eye_z,
  input  wire q16_t in_target_x,
  input  wire q16_t in_target_y,
  input  wire q16_t in_target_z,
  input  wire q16_t in_up_x,
  input  wire q16_t in_up_y,
  input  wire q16_t in_up_z,
  output logic      out_valid,
  input  wire logic out_stall,
  output q14_t      out_r11,
  output q14_t      out_r12,
  output q14_t      out_r13,
  output q14_t      out_r21,
  output q14_t      out_r22,
  output q14_t      out_r23,
  output q14_t      out_r31,
  output q14_t      out_r32,
  output q14_t      out_r33,
  output q16_t      out_trans_x,
  output q16_t      out_trans_y,
  output q16_t      out_trans_z
);

  typedef struct packed {
    q14_t [2:0] xa;
    q14_t [2:0] ya;
    q14_t [2:0] za;
    q16_t [2:0] tr;
  } res_t;

  logic en;
  logic skid_v_r;
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // stage A: capture word, form eye - target
  logic                a_v_r;
  logic signed [32:0]  d_r [3];
  q16_t                eye_a_r [3];
  q16_t                up_a_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]     <= 33'(in_eye_x) - 33'(in_target_x);
      d_r[1]     <= 33'(in_eye_y) - 33'(in_target_y);
      d_r[2]     <= 33'(in_eye_z) - 33'(in_target_z);
      eye_a_r[0] <= in_eye_x;
      eye_a_r[1] <= in_eye_y;
      eye_a_r[2] <= in_eye_z;
      up_a_r[0]  <= in_up_x;
      up_a_r[1]  <= in_up_y;
      up_a_r[2]  <= in_up_z;
    end
  end

  // forward axis
  logic zn_v;
  q14_t zn [3];

  lav_norm #(.W(33)) u_norm_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (a_v_r),
    .in_vec  (d_r),
    .out_v   (zn_v),
    .out_vec (zn)
  );

  // hold eye and up alongside the forward normalize
  logic [191:0] eu_b;
  q16_t         eye_b [3];
  q16_t         up_b [3];

  lav_delay #(.W(192), .DEPTH(NORM_LAT)) u_dly_eu (
    .clk  (clk),
    .en   (en),
    .din  ({eye_a_r[0], eye_a_r[1], eye_a_r[2], up_a_r[0], up_a_r[1], up_a_r[2]}),
    .dout (eu_b)
  );

  assign eye_b[0] = eu_b[191:160];
  assign eye_b[1] = eu_b[159:128];
  assign eye_b[2] = eu_b[127:96];
  assign up_b[0]  = eu_b[95:64];
  assign up_b[1]  = eu_b[63:32];
  assign up_b[2]  = eu_b[31:0];

  // stage P: up cross z partial products
  logic               p_v_r;
  logic signed [47:0] pa_r [3];
  logic signed [47:0] pb_r [3];
  q14_t               z_p_r [3];
  q16_t               eye_p_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= zn_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= 48'(up_b[(i+1)%3]) * 48'(zn[(i+2)%3]);
        pb_r[i] <= 48'(up_b[(i+2)%3]) * 48'(zn[(i+1)%3]);
      end
      z_p_r   <= zn;
      eye_p_r <= eye_b;
    end
  end

  // stage Q: up cross z
  logic               q_v_r;
  logic signed [47:0] c_q_r [3];
  q14_t               z_q_r [3];
  q16_t               eye_q_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else if (en) begin
      q_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_q_r[i] <= pa_r[i] - pb_r[i];
      end
      z_q_r   <= z_p_r;
      eye_q_r <= eye_p_r;
    end
  end

  // right axis
  logic xn_v;
  q14_t xn [3];

  lav_norm #(.W(48)) u_norm_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (q_v_r),
    .in_vec  (c_q_r),
    .out_v   (xn_v),
    .out_vec (xn)
  );

  logic [143:0] ze_c;
  q14_t         z_c [3];
  q16_t         eye_c [3];

  lav_delay #(.W(144), .DEPTH(NORM_LAT)) u_dly_ze (
    .clk  (clk),
    .en   (en),
    .din  ({z_q_r[0], z_q_r[1], z_q_r[2], eye_q_r[0], eye_q_r[1], eye_q_r[2]}),
    .dout (ze_c)
  );

  assign z_c[0]   = ze_c[143:128];
  assign z_c[1]   = ze_c[127:112];
  assign z_c[2]   = ze_c[111:96];
  assign eye_c[0] = ze_c[95:64];
  assign eye_c[1] = ze_c[63:32];
  assign eye_c[2] = ze_c[31:0];

  // stage Y1: z cross x partial products
  logic               y1_v_r;
  logic signed [31:0] ya_r [3];
  logic signed [31:0] yb_r [3];
  q14_t               x_y1_r [3];
  q14_t               z_y1_r [3];
  q16_t               eye_y1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_v_r <= 1'b0;
    end else if (en) begin
      y1_v_r <= xn_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ya_r[i] <= 32'(z_c[(i+1)%3]) * 32'(xn[(i+2)%3]);
        yb_r[i] <= 32'(z_c[(i+2)%3]) * 32'(xn[(i+1)%3]);
      end
      x_y1_r   <= xn;
      z_y1_r   <= z_c;
      eye_y1_r <= eye_c;
    end
  end

  // stage Y2: z cross x in Q2.28
  logic               y2_v_r;
  logic signed [31:0] yc_r [3];
  q14_t               x_y2_r [3];
  q14_t               z_y2_r [3];
  q16_t               eye_y2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y2_v_r <= 1'b0;
    end else if (en) begin
      y2_v_r <= y1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        yc_r[i] <= ya_r[i] - yb_r[i];
      end
      x_y2_r   <= x_y1_r;
      z_y2_r   <= z_y1_r;
      eye_y2_r <= eye_y1_r;
    end
  end

  // stage Y3: round to Q1.14 and clamp
  logic        y3_v_r;
  q14_t        y_y3_r [3];
  q14_t        x_y3_r [3];
  q14_t        z_y3_r [3];
  q16_t        eye_y3_r [3];
  logic [31:0] ymag_nxt [3];
  logic [17:0] yrnd_nxt [3];
  q14_t        ycl_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ymag_nxt[i] = yc_r[i][31] ? 32'(-yc_r[i]) : 32'(yc_r[i]);
      yrnd_nxt[i] = 18'((ymag_nxt[i] + 32'(RND_HALF)) >> 14);
      if (yrnd_nxt[i] > 18'(Q14_ONE)) begin
        ycl_nxt[i] = q14_t'(Q14_ONE);
      end else begin
        ycl_nxt[i] = q14_t'(yrnd_nxt[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y3_v_r <= 1'b0;
    end else if (en) begin
      y3_v_r <= y2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        y_y3_r[i] <= yc_r[i][31] ? -ycl_nxt[i] : ycl_nxt[i];
      end
      x_y3_r   <= x_y2_r;
      z_y3_r   <= z_y2_r;
      eye_y3_r <= eye_y2_r;
    end
  end

  // stage D1: axis times eye products
  logic               d1_v_r;
  logic signed [47:0] dp_r [3][3];
  res_t               rot_d1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
    end else if (en) begin
      d1_v_r <= y3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dp_r[0][i] <= 48'(x_y3_r[i]) * 48'(eye_y3_r[i]);
        dp_r[1][i] <= 48'(y_y3_r[i]) * 48'(eye_y3_r[i]);
        dp_r[2][i] <= 48'(z_y3_r[i]) * 48'(eye_y3_r[i]);
        rot_d1_r.xa[i] <= x_y3_r[i];
        rot_d1_r.ya[i] <= y_y3_r[i];
        rot_d1_r.za[i] <= z_y3_r[i];
        rot_d1_r.tr[i] <= '0;
      end
    end
  end

  // stage D2: dot product sums in Q17.30
  logic               d2_v_r;
  logic signed [49:0] ds_r [3];
  res_t               rot_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_v_r <= 1'b0;
    end else if (en) begin
      d2_v_r <= d1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        ds_r[a] <= 50'(dp_r[a][0]) + 50'(dp_r[a][1]) + 50'(dp_r[a][2]);
      end
      rot_d2_r <= rot_d1_r;
    end
  end

  // stage D3: round to Q16.16, negate, saturate
  logic        d3_v_r;
  res_t        res_d3_r;
  logic [49:0] dmag_nxt [3];
  logic [35:0] drnd_nxt [3];
  q16_t        tr_nxt [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dmag_nxt[a] = ds_r[a][49] ? 50'(-ds_r[a]) : 50'(ds_r[a]);
      drnd_nxt[a] = 36'((dmag_nxt[a] + 50'(RND_HALF)) >> 14);
      if (ds_r[a][49]) begin
        // negative sum: result is +rnd, clip at the top
        if (drnd_nxt[a] > 36'h07FFFFFFF) begin
          tr_nxt[a] = 32'sh7FFFFFFF;
        end else begin
          tr_nxt[a] = q16_t'(drnd_nxt[a][31:0]);
        end
      end else begin
        // positive sum: result is -rnd, clip at the bottom
        if (drnd_nxt[a] > 36'h080000000) begin
          tr_nxt[a] = 32'sh80000000;
        end else begin
          tr_nxt[a] = -q16_t'(drnd_nxt[a][31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d3_v_r <= 1'b0;
    end else if (en) begin
      d3_v_r <= d2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_d3_r.xa <= rot_d2_r.xa;
      res_d3_r.ya <= rot_d2_r.ya;
      res_d3_r.za <= rot_d2_r.za;
      for (int a = 0; a < 3; a++) begin
        res_d3_r.tr[a] <= tr_nxt[a];
      end
    end
  end

  // output register with skid stage
  logic out_v_r;
  res_t out_r;
  res_t skid_r;
  logic out_take;

  assign out_take = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (d3_v_r) begin
      if (out_take) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (d3_v_r) begin
      if (out_take) begin
        out_r <= res_d3_r;
      end else begin
        skid_r <= res_d3_r;
      end
    end
  end

  assign out_valid   = out_v_r;
  assign out_r11     = out_r.xa[0];
  assign out_r21     = out_r.xa[1];
  assign out_r31     = out_r.xa[2];
  assign out_r12     = out_r.ya[0];
  assign out_r22     = out_r.ya[1];
  assign out_r32     = out_r.ya[2];
  assign out_r13     = out_r.za[0];
  assign out_r23     = out_r.za[1];
  assign out_r33     = out_r.za[2];
  assign out_trans_x = out_r.tr[0];
  assign out_trans_y = out_r.tr[1];
  assign out_trans_z = out_r.tr[2];

endmodule

`default_nettype wire

@@ tb/sv/look_at_view_matrix_checker.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix_checker
// Watches both channels of the look-at pipeline, predicts each result word
// from the accepted input word and compares them field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module look_at_view_matrix_checker
  import lav_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_stall,
  input  wire q16_t in_eye_x,
  input  wire q16_t in_eye_y,
  input  wire q16_t in_eye_z,
  input  wire q16_t in_target_x,
  input  wire q16_t in_target_y,
  input  wire q16_t in_target_z,
  input  wire q16_t in_up_x,
  input  wire q16_t in_up_y,
  input  wire q16_t in_up_z,
  input  wire logic out_valid,
  input  wire logic out_stall,
  input  wire q14_t out_r11,
  input  wire q14_t out_r12,
  input  wire q14_t out_r13,
  input  wire q14_t out_r21,
  input  wire q14_t out_r22,
  input  wire q14_t out_r23,
  input  wire q14_t out_r31,
  input  wire q14_t out_r32,
  input  wire q14_t out_r33,
  input  wire q16_t out_trans_x,
  input  wire q16_t out_trans_y,
  input  wire q16_t out_trans_z,
  output int        fail_count,
  output int        pending_count
);

  typedef struct packed {
    q14_t [8:0] rot;    // r11 r12 r13 r21 r22 r23 r31 r32 r33, rot[0] = r11
    q16_t [2:0] trans;
  } view_word_t;

  typedef logic signed [63:0] s64_t;

  view_word_t view_queue[$];

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale to a Q1.14 unit vector; zero stays zero
  function automatic void to_unit(input s64_t v[3], output s64_t u[3]);
    logic [63:0] mag[3];
    logic [63:0] m, sum, len, q;
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (m >= (64'd1 << 24)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 23)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    len = isqrt64(sum);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * Q14_ONE + len / 2) / len;
      u[i] = v[i] < 0 ? -s64_t'(q) : s64_t'(q);
    end
  endfunction

  function automatic void cross3(input s64_t a[3], input s64_t b[3], output s64_t c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic s64_t round14(s64_t s);
    logic [63:0] mag;
    s64_t r;
    mag = s < 0 ? -s : s;
    r = s64_t'((mag + RND_HALF) >> 14);
    return s < 0 ? -r : r;
  endfunction

  function automatic q16_t neg_dot_sat(s64_t ax[3], s64_t e[3]);
    s64_t t;
    t = -round14(ax[0] * e[0] + ax[1] * e[1] + ax[2] * e[2]);
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return q16_t'(t);
  endfunction

  function automatic view_word_t predict_view(s64_t e[3], s64_t t[3], s64_t up[3]);
    s64_t d[3], c[3], xa[3], ya[3], za[3];
    view_word_t w;
    for (int i = 0; i < 3; i++) d[i] = e[i] - t[i];
    to_unit(d, za);
    cross3(up, za, c);
    to_unit(c, xa);
    cross3(za, xa, c);
    for (int i = 0; i < 3; i++) begin
      ya[i] = round14(c[i]);
      if (ya[i] > Q14_ONE) ya[i] = Q14_ONE;
      if (ya[i] < -Q14_ONE) ya[i] = -Q14_ONE;
    end
    for (int i = 0; i < 3; i++) begin
      w.rot[3*i]   = q14_t'(xa[i]);
      w.rot[3*i+1] = q14_t'(ya[i]);
      w.rot[3*i+2] = q14_t'(za[i]);
    end
    w.trans[0] = neg_dot_sat(xa, e);
    w.trans[1] = neg_dot_sat(ya, e);
    w.trans[2] = neg_dot_sat(za, e);
    return w;
  endfunction

  assign pending_count = view_queue.size();

  // Predict on input accept, compare on output accept
  always @(posedge clk) begin
    s64_t e[3], t[3], u[3];
    view_word_t want, got;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        e = '{in_eye_x, in_eye_y, in_eye_z};
        t = '{in_target_x, in_target_y, in_target_z};
        u = '{in_up_x, in_up_y, in_up_z};
        view_queue.push_back(predict_view(e, t, u));
      end
      if (out_valid && !out_stall) begin
        got.rot = {out_r33, out_r32, out_r31, out_r23, out_r22, out_r21,
                   out_r13, out_r12, out_r11};
        got.trans = {out_trans_z, out_trans_y, out_trans_x};
        if (view_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word");
          fail_count <= fail_count + 1;
        end else begin
          want = view_queue.pop_front();
          if (want != got) begin
            if (fail_count < 10) begin
              for (int i = 0; i < 9; i++)
                if (want.rot[i] != got.rot[i])
                  $display("r%0d%0d: expected %0d, got %0d", i / 3 + 1, i % 3 + 1,
                           want.rot[i], got.rot[i]);
              for (int i = 0; i < 3; i++)
                if (want.trans[i] != got.trans[i])
                  $display("trans[%0d]: expected %0d, got %0d", i,
                           want.trans[i], got.trans[i]);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/look_at_view_matrix_test.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix_test
// Drives directed and random camera words through the look-at pipeline with
// random idling on both channels, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module look_at_view_matrix_test
  import lav_pkg::*;
();

  localparam int N_DIRECTED = 20;
  localparam int N_RANDOM   = 700;
  localparam int LATENCY    = 106;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  q16_t in_eye_x = 0, in_eye_y = 0, in_eye_z = 0;
  q16_t in_target_x = 0, in_target_y = 0, in_target_z = 0;
  q16_t in_up_x = 0, in_up_y = 0, in_up_z = 0;
  logic out_valid;
  logic out_stall = 0;
  q14_t out_r11, out_r12, out_r13, out_r21, out_r22, out_r23;
  q14_t out_r31, out_r32, out_r33;
  q16_t out_trans_x, out_trans_y, out_trans_z;
  int   fail_count, pending_count;
  int   sent = 0;
  logic calm = 0;        // no idling in the last part
  logic hold_out = 0;    // long receiver hold-off request
  q16_t word[9];

  always #1 clk = ~clk;

  look_at_view_matrix dut (.*);
  look_at_view_matrix_checker chk (.*);

  function automatic q16_t rand_q16(int mode);
    case (mode)
      0: return q16_t'($urandom);
      1: return q16_t'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      2: return q16_t'($urandom_range(0, 255)) - 128;
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  // Build one camera word; directed ones cover edges and degenerate cases
  task automatic make_word(int n);
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++)
      word[i] = rand_q16(mode < 5 ? 1 : mode < 7 ? 0 : mode < 9 ? 2 : $urandom_range(0, 3));
    case (n)
      0: foreach (word[i]) word[i] = 0;
      1: foreach (word[i]) word[i] = 32'sh7FFF_FFFF;
      2: foreach (word[i]) word[i] = 32'sh8000_0000;
      3: begin
        word = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh10000, 0};
      end
      4: for (int i = 0; i < 3; i++) word[3 + i] = word[i];     // eye on target
      5: for (int i = 0; i < 3; i++) word[6 + i] = word[i] - word[3 + i];  // up along view
      6: word = '{0, 0, 32'sh50000, 0, 0, 0, 0, 32'sh10000, 0};
      7: word = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0,
                  0, 32'sh10000, 0};
      8: word = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh1, 0, 0};
      9: word = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
      default: ;
    endcase
  endtask

  task automatic send_word();
    in_eye_x <= word[0]; in_eye_y <= word[1]; in_eye_z <= word[2];
    in_target_x <= word[3]; in_target_y <= word[4]; in_target_z <= word[5];
    in_up_x <= word[6]; in_up_y <= word[7]; in_up_z <= word[8];
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Receiver stall: random bursts, or one long hold-off on request
  always @(posedge clk) begin
    int gap;
    if (rst_n && !calm) begin
      if (hold_out) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        out_stall <= 0;
        hold_out = 0;
      end else if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 17);
        out_stall <= 1;
        repeat (gap) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  initial begin
    int gap;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int n = 0; n < N_DIRECTED + N_RANDOM; n++) begin
      if (n == 100) hold_out = 1;
      if (n == 300) begin
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
      end
      if (n == N_DIRECTED + N_RANDOM - 120) calm = 1;
      if (!calm && n > 120 && n < 140) ;   // keep pushing into the hold-off
      else if (!calm && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 17);
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      make_word(n);
      send_word();
    end
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/lav_pkg.sv
rtl/core/lav_delay.sv
rtl/core/lav_norm.sv
rtl/core/look_at_view_matrix.sv
tb/sv/look_at_view_matrix_checker.sv
tb/sv/look_at_view_matrix_test.sv
